// ===== rtl/plat_pkg.sv =====
// Shared codes for the pair link accumulate table.
`timescale 1ns / 1ps
package plat_pkg;

	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_REPORT = 1'b1;

	localparam logic KIND_ADD    = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	localparam logic [1:0] ST_NEW    = 2'd0;
	localparam logic [1:0] ST_MERGED = 2'd1;
	localparam logic [1:0] ST_RANGE  = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	localparam logic REG_PAIR_CUTOFF = 1'b0;
	localparam logic REG_READ_CUTOFF = 1'b1;

	localparam int CNT_W  = 32;
	localparam int CONTIG_W = 10;
	localparam int AVG_W  = 21;
	localparam int PROD_W = 38;

	localparam logic signed [AVG_W-1:0] AVG_MAX = 21'sd1048575;
	localparam logic signed [AVG_W-1:0] AVG_MIN = -21'sd1048576;

endpackage

// ===== rtl/plat_div.sv =====
// Restoring divider, one quotient bit per cycle, 32-bit divisor.
`timescale 1ns / 1ps
module plat_div
	import plat_pkg::*;
#(
	parameter int NUM_W = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [CNT_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int CW = (NUM_W > 1) ? $clog2(NUM_W) : 1;

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] den_q;
	logic [CNT_W:0]   shifted;
	logic [CNT_W:0]   diff;
	logic             ge;

	assign shifted = {rem_q, num_q[NUM_W-1]};
	assign ge      = shifted >= {1'b0, den_q};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== rtl/pair_link_accumulate_table.sv =====
// Top level: link table with row search sequencer, entry memory and report walk.
`timescale 1ns / 1ps
// Pair link accumulate table. Pulse start with the item fields while busy is
// low; for an in-range item the block raises busy and works it through a
// small sequencer, while an out-of-range item is answered from idle. Results
// come out one at a time on the registered result ports, each valid for
// exactly one cycle while strobe is high; the receiver cannot stall, so it
// must take every strobe. An add item gives one result; an in-range add scans
// the row entries until a hit or the row fill. A report item scans its row
// and, for each entry that passes both cutoffs, waits on the single shared
// bit-serial divider that forms the average. A report result is held back one
// step so that last can be set on the final one. After reset the row fill
// memory is cleared one row per cycle with busy high; cutoff writes are taken
// at any time (cfg_ready is always high).
module pair_link_accumulate_table
	import plat_pkg::*;
#(
	parameter int ROWS            = 1024,
	parameter int ENTRIES_PER_ROW = 16,
	parameter int DIST_SUM_BITS   = 48
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       op,
	input  logic [CONTIG_W-1:0]        source_contig,
	input  logic [CONTIG_W-1:0]        dest_contig,
	input  logic [15:0]                pair_increment,
	input  logic signed [20:0]         distance,
	input  logic [15:0]                read_increment,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_index,
	input  logic [CNT_W-1:0]           cfg_data,
	output logic                       strobe,
	output logic                       kind,
	output logic [1:0]                 status,
	output logic [CONTIG_W-1:0]        link_source,
	output logic [CONTIG_W-1:0]        link_dest,
	output logic signed [AVG_W-1:0]    avg_distance,
	output logic [CNT_W-1:0]           link_pair_count,
	output logic                       link_valid,
	output logic                       last
);

	localparam int DEPTH = ROWS * ENTRIES_PER_ROW;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = $clog2(ROWS);
	localparam int EW    = $clog2(ENTRIES_PER_ROW + 1);
	localparam int NW    = DIST_SUM_BITS;
	localparam int SW    = ((NW > PROD_W) ? NW : PROD_W) + 1;
	localparam logic signed [SW-1:0] SUM_MAX = (SW'(1) <<< (NW - 1)) - SW'(1);
	localparam logic signed [SW-1:0] SUM_MIN = -SUM_MAX - SW'(1);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_FILL, S_ENT_RD, S_ENT_CHK, S_DIV
	} state_t;

	state_t state_q;

	// configuration
	logic [CNT_W-1:0] pair_cut_q, read_cut_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_cut_q <= CNT_W'(1);
			read_cut_q <= CNT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PAIR_CUTOFF: pair_cut_q <= cfg_data;
				REG_READ_CUTOFF: read_cut_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// item registers
	logic                     op_q;
	logic [RW-1:0]            row_q;
	logic [CONTIG_W-1:0]      src_q, dst_q;
	logic [15:0]              pinc_q, rinc_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [EW-1:0]            fill_q, e_q;
	logic [AW-1:0]            base_q, addr_q;

	// row fill memory
	logic [EW-1:0] fill_mem [ROWS];
	logic [EW-1:0] fill_rd_q;
	logic          fill_we;
	logic [RW-1:0] fill_wa, fill_ra, clr_q;
	logic [EW-1:0] fill_wd;

	always_ff @(posedge clk) begin
		if (fill_we) begin
			fill_mem[fill_wa] <= fill_wd;
		end
		fill_rd_q <= fill_mem[fill_ra];
	end

	// entry memory
	logic [CONTIG_W-1:0]    dest_mem [DEPTH];
	logic signed [NW-1:0]   sum_mem  [DEPTH];
	logic [CNT_W-1:0]       pc_mem   [DEPTH];
	logic [CNT_W-1:0]       rc_mem   [DEPTH];
	logic [CONTIG_W-1:0]    rd_dest_q;
	logic signed [NW-1:0]   rd_sum_q;
	logic [CNT_W-1:0]       rd_pc_q, rd_rc_q;
	logic                   ent_we;
	logic [AW-1:0]          ent_wa, ent_ra;
	logic [CONTIG_W-1:0]    wr_dest;
	logic signed [NW-1:0]   wr_sum;
	logic [CNT_W-1:0]       wr_pc, wr_rc;

	always_ff @(posedge clk) begin
		if (ent_we) begin
			dest_mem[ent_wa] <= wr_dest;
			sum_mem[ent_wa]  <= wr_sum;
			pc_mem[ent_wa]   <= wr_pc;
			rc_mem[ent_wa]   <= wr_rc;
		end
		rd_dest_q <= dest_mem[ent_ra];
		rd_sum_q  <= sum_mem[ent_ra];
		rd_pc_q   <= pc_mem[ent_ra];
		rd_rc_q   <= rc_mem[ent_ra];
	end

	// saturating accumulate, shared by hit and new entry
	logic                   hit;
	logic signed [SW-1:0]   acc_a, acc_s;
	logic [CNT_W:0]         pc_s, rc_s;

	assign hit   = (rd_dest_q == dst_q);
	assign acc_a = (state_q == S_ENT_CHK) ? SW'(rd_sum_q) : '0;
	assign acc_s = acc_a + SW'(prod_q);
	assign pc_s  = {1'b0, rd_pc_q} + {{(CNT_W-15){1'b0}}, pinc_q};
	assign rc_s  = {1'b0, rd_rc_q} + {{(CNT_W-15){1'b0}}, rinc_q};

	always_comb begin
		if (acc_s > SUM_MAX) begin
			wr_sum = NW'(SUM_MAX);
		end else if (acc_s < SUM_MIN) begin
			wr_sum = NW'(SUM_MIN);
		end else begin
			wr_sum = NW'(acc_s);
		end
		wr_dest = dst_q;
		if (state_q == S_ENT_CHK) begin
			wr_pc = pc_s[CNT_W] ? '1 : pc_s[CNT_W-1:0];
			wr_rc = rc_s[CNT_W] ? '1 : rc_s[CNT_W-1:0];
		end else begin
			wr_pc = CNT_W'(pinc_q);
			wr_rc = CNT_W'(1);
		end
	end

	// report qualification and divider
	logic             qualify;
	logic             div_start, div_done;
	logic             neg_q;
	logic [NW-1:0]    mag;
	logic [NW-1:0]    quo;
	logic [CNT_W-1:0] cur_pc_q;
	logic [CONTIG_W-1:0] cur_dest_q;
	logic signed [AVG_W-1:0] avg;

	assign qualify   = (rd_pc_q >= pair_cut_q) && (rd_rc_q >= read_cut_q);
	assign div_start = (state_q == S_ENT_CHK) && (op_q == OP_REPORT) && qualify;
	assign mag       = rd_sum_q[NW-1] ? NW'(-rd_sum_q) : NW'(rd_sum_q);

	plat_div #(.NUM_W(NW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (mag),
		.den    (rd_pc_q),
		.done   (div_done),
		.quo    (quo)
	);

	always_comb begin
		if (cur_pc_q == '0) begin
			avg = '0;
		end else if (!neg_q) begin
			avg = (quo > NW'(AVG_MAX)) ? AVG_MAX : AVG_W'(quo);
		end else begin
			avg = (quo > NW'(1048576)) ? AVG_MIN : AVG_W'(-quo);
		end
	end

	// result held back until the next one (or end of row) is known
	logic                    pend_v_q;
	logic [CONTIG_W-1:0]     pend_dest_q;
	logic signed [AVG_W-1:0] pend_avg_q;
	logic [CNT_W-1:0]        pend_pc_q;

	// memory port steering
	always_comb begin
		fill_ra = RW'(source_contig);
		fill_we = 1'b0;
		fill_wa = row_q;
		fill_wd = fill_q + 1'b1;
		ent_we  = 1'b0;
		ent_wa  = addr_q;
		ent_ra  = base_q + AW'(e_q);
		unique case (state_q)
			S_CLEAR: begin
				fill_we = 1'b1;
				fill_wa = clr_q;
				fill_wd = '0;
			end
			S_ENT_RD: begin
				if (e_q == fill_q && op_q == OP_ADD
				    && fill_q != EW'(ENTRIES_PER_ROW)) begin
					fill_we = 1'b1;
					ent_we  = 1'b1;
					ent_wa  = base_q + AW'(fill_q);
				end
			end
			S_ENT_CHK: begin
				ent_we = (op_q == OP_ADD) && hit;
			end
			default: ;
		endcase
	end

	// sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			strobe   <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == RW'(ROWS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						op_q   <= op;
						row_q  <= RW'(source_contig);
						src_q  <= source_contig;
						dst_q  <= dest_contig;
						pinc_q <= pair_increment;
						rinc_q <= read_increment;
						prod_q <= $signed({1'b0, pair_increment}) * distance;
						pend_v_q <= 1'b0;
						if (32'(source_contig) >= ROWS
						    || (op == OP_ADD && 32'(dest_contig) >= ROWS)) begin
							strobe          <= 1'b1;
							kind            <= (op == OP_ADD) ? KIND_ADD : KIND_REPORT;
							status          <= ST_RANGE;
							link_source     <= '0;
							link_dest       <= '0;
							avg_distance    <= '0;
							link_pair_count <= '0;
							link_valid      <= 1'b0;
							last            <= 1'b1;
						end else begin
							state_q <= S_FILL;
						end
					end
				end
				S_FILL: begin
					fill_q  <= (fill_rd_q > EW'(ENTRIES_PER_ROW))
					           ? EW'(ENTRIES_PER_ROW) : fill_rd_q;
					base_q  <= AW'(row_q * ENTRIES_PER_ROW);
					e_q     <= '0;
					state_q <= S_ENT_RD;
				end
				S_ENT_RD: begin
					addr_q <= base_q + AW'(e_q);
					if (e_q == fill_q) begin
						strobe          <= 1'b1;
						link_source     <= '0;
						link_dest       <= '0;
						avg_distance    <= '0;
						link_pair_count <= '0;
						link_valid      <= 1'b0;
						last            <= 1'b1;
						status          <= ST_NEW;
						state_q         <= S_IDLE;
						if (op_q == OP_ADD) begin
							kind <= KIND_ADD;
							if (fill_q == EW'(ENTRIES_PER_ROW)) begin
								status <= ST_FULL;
							end
						end else begin
							kind <= KIND_REPORT;
							if (pend_v_q) begin
								link_source     <= src_q;
								link_dest       <= pend_dest_q;
								avg_distance    <= pend_avg_q;
								link_pair_count <= pend_pc_q;
								link_valid      <= 1'b1;
							end
						end
					end else begin
						state_q <= S_ENT_CHK;
					end
				end
				S_ENT_CHK: begin
					cur_pc_q   <= rd_pc_q;
					cur_dest_q <= rd_dest_q;
					neg_q      <= rd_sum_q[NW-1];
					if (op_q == OP_ADD) begin
						if (hit) begin
							strobe          <= 1'b1;
							kind            <= KIND_ADD;
							status          <= ST_MERGED;
							link_source     <= '0;
							link_dest       <= '0;
							avg_distance    <= '0;
							link_pair_count <= '0;
							link_valid      <= 1'b0;
							last            <= 1'b1;
							state_q         <= S_IDLE;
						end else begin
							e_q     <= e_q + 1'b1;
							state_q <= S_ENT_RD;
						end
					end else if (qualify) begin
						state_q <= S_DIV;
					end else begin
						e_q     <= e_q + 1'b1;
						state_q <= S_ENT_RD;
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (pend_v_q) begin
							strobe          <= 1'b1;
							kind            <= KIND_REPORT;
							status          <= ST_NEW;
							link_source     <= src_q;
							link_dest       <= pend_dest_q;
							avg_distance    <= pend_avg_q;
							link_pair_count <= pend_pc_q;
							link_valid      <= 1'b1;
							last            <= 1'b0;
						end
						pend_v_q    <= 1'b1;
						pend_dest_q <= cur_dest_q;
						pend_avg_q  <= avg;
						pend_pc_q   <= cur_pc_q;
						e_q         <= e_q + 1'b1;
						state_q     <= S_ENT_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

	// checks
	a_add_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind == KIND_ADD |-> last)
		else $error("add result without last");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !link_valid |-> last)
		else $error("empty result not final");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (status == ST_RANGE || status == ST_FULL) |-> last)
		else $error("error status on non-final result");

	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside report step");

endmodule

// ===== verif/tb_pair_link_accumulate_table.sv =====
// Testbench for the pair link accumulate table: directed and random items against a local model.
`timescale 1ns / 1ps
module tb_pair_link_accumulate_table;
	import plat_pkg::*;

	localparam int NROWS      = 1024;
	localparam int ROW_SLOTS  = 16;
	localparam int SUM_BITS   = 48;
	// Worst case: every item a full-row report dividing on all sixteen entries, plus gaps.
	localparam int CYCLE_LIMIT = 4000000;
	localparam longint SUM_HI = (64'sd1 <<< (SUM_BITS - 1)) - 1;
	localparam longint SUM_LO = -SUM_HI - 1;
	localparam logic [31:0] CNT_SAT = 32'hFFFF_FFFF;

	// One result as seen on the result ports.
	typedef struct packed {
		logic                    kind;
		logic [1:0]              status;
		logic [CONTIG_W-1:0]     src;
		logic [CONTIG_W-1:0]     dst;
		logic signed [AVG_W-1:0] avg;
		logic [CNT_W-1:0]        pairs;
		logic                    valid;
		logic                    last;
	} link_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic op = OP_ADD;
	logic [CONTIG_W-1:0] source_contig = '0;
	logic [CONTIG_W-1:0] dest_contig = '0;
	logic [15:0] pair_increment = '0;
	logic signed [20:0] distance = '0;
	logic [15:0] read_increment = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = REG_PAIR_CUTOFF;
	logic [CNT_W-1:0] cfg_data = '0;
	logic strobe, kind, link_valid, last;
	logic [1:0] status;
	logic [CONTIG_W-1:0] link_source, link_dest;
	logic signed [AVG_W-1:0] avg_distance;
	logic [CNT_W-1:0] link_pair_count;

	pair_link_accumulate_table u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.source_contig(source_contig), .dest_contig(dest_contig),
		.pair_increment(pair_increment), .distance(distance),
		.read_increment(read_increment), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.strobe(strobe), .kind(kind), .status(status),
		.link_source(link_source), .link_dest(link_dest),
		.avg_distance(avg_distance), .link_pair_count(link_pair_count),
		.link_valid(link_valid), .last(last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Local copy of the link table and the cutoffs.
	logic [4:0]          fill_of_row [NROWS];
	logic [CONTIG_W-1:0] link_dst    [NROWS][ROW_SLOTS];
	longint              link_sum    [NROWS][ROW_SLOTS];
	logic [31:0]         link_pairs  [NROWS][ROW_SLOTS];
	logic [31:0]         link_reads  [NROWS][ROW_SLOTS];
	logic [31:0] pair_cutoff = 32'd1;
	logic [31:0] read_cutoff = 32'd1;

	link_result_t pending_results[$];
	int  mismatch_count = 0;
	int  cycle_count = 0;
	bit  sender_gaps = 1'b0;

	initial begin
		foreach (fill_of_row[r])
			fill_of_row[r] = '0;
	end

	function automatic longint sum_sat(longint a, longint b);
		if (b > 0 && a > SUM_HI - b) return SUM_HI;
		if (b < 0 && a < SUM_LO - b) return SUM_LO;
		return a + b;
	endfunction

	function automatic logic [31:0] count_sat(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? CNT_SAT : s[31:0];
	endfunction

	function automatic link_result_t status_result(logic k, logic [1:0] st);
		link_result_t r;
		r = '0;
		r.kind = k;
		r.status = st;
		r.last = 1'b1;
		return r;
	endfunction

	// Appends one expected result at the tail of the queue.
	function automatic void expect_result(link_result_t r);
		pending_results = {pending_results, r};
	endfunction

	// Updates the local table for one accepted item and queues its results.
	function automatic void predict_links(logic o, logic [9:0] s, logic [9:0] d,
			logic [15:0] pinc, logic signed [20:0] dist_val, logic [15:0] rinc);
		longint prod, avg;
		int n;
		link_result_t r;
		n = 0;
		prod = longint'(pinc) * longint'(dist_val);
		if (o == OP_ADD) begin
			if (int'(s) >= NROWS || int'(d) >= NROWS) begin
				expect_result(status_result(KIND_ADD, ST_RANGE));
				return;
			end
			for (int e = 0; e < fill_of_row[s]; e++) begin
				if (link_dst[s][e] == d) begin
					link_sum[s][e] = sum_sat(link_sum[s][e], prod);
					link_pairs[s][e] = count_sat(link_pairs[s][e], {16'd0, pinc});
					link_reads[s][e] = count_sat(link_reads[s][e], {16'd0, rinc});
					expect_result(status_result(KIND_ADD, ST_MERGED));
					return;
				end
			end
			if (fill_of_row[s] >= ROW_SLOTS) begin
				expect_result(status_result(KIND_ADD, ST_FULL));
				return;
			end
			link_dst[s][fill_of_row[s]] = d;
			link_sum[s][fill_of_row[s]] = sum_sat(0, prod);
			link_pairs[s][fill_of_row[s]] = {16'd0, pinc};
			link_reads[s][fill_of_row[s]] = 32'd1;
			fill_of_row[s] = fill_of_row[s] + 5'd1;
			expect_result(status_result(KIND_ADD, ST_NEW));
		end else begin
			if (int'(s) >= NROWS) begin
				expect_result(status_result(KIND_REPORT, ST_RANGE));
				return;
			end
			for (int e = 0; e < fill_of_row[s]; e++) begin
				if (link_pairs[s][e] < pair_cutoff || link_reads[s][e] < read_cutoff)
					continue;
				avg = 0;
				if (link_pairs[s][e] != 0)
					avg = link_sum[s][e] / longint'(link_pairs[s][e]);
				if (avg > 1048575) avg = 1048575;
				if (avg < -1048576) avg = -1048576;
				r = '0;
				r.kind = KIND_REPORT;
				r.status = ST_NEW;
				r.src = s;
				r.dst = link_dst[s][e];
				r.avg = avg[AVG_W-1:0];
				r.pairs = link_pairs[s][e];
				r.valid = 1'b1;
				expect_result(r);
				n++;
			end
			if (n == 0)
				expect_result(status_result(KIND_REPORT, ST_NEW));
			else
				pending_results[pending_results.size()-1].last = 1'b1;
		end
	endfunction

	// Result checker: every strobe is a result that must match the oldest expectation.
	always @(posedge clk) begin
		link_result_t seen, want;
		if (arst_n && strobe) begin
			seen = '{kind, status, link_source, link_dest, avg_distance,
				link_pair_count, link_valid, last};
			if (pending_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result kind=%0d status=%0d", $time, kind, status);
			end else begin
				want = pending_results.pop_front();
				if (seen !== want) begin
					mismatch_count++;
					$display("%0t: expected kind=%0d st=%0d src=%0d dst=%0d avg=%0d pc=%0d v=%0d last=%0d",
						$time, want.kind, want.status, want.src, want.dst, want.avg,
						want.pairs, want.valid, want.last);
					$display("%0t:   actual kind=%0d st=%0d src=%0d dst=%0d avg=%0d pc=%0d v=%0d last=%0d",
						$time, seen.kind, seen.status, seen.src, seen.dst, seen.avg,
						seen.pairs, seen.valid, seen.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic sender_idle(int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Sends one item; start stays high afterwards so back-to-back items need no gap.
	task automatic send_item(logic o, logic [9:0] s, logic [9:0] d, logic [15:0] pinc,
			logic signed [20:0] dist_val, logic [15:0] rinc);
		if (sender_gaps && $urandom_range(0, 3) == 0)
			sender_idle($urandom_range(1, 12));
		start <= 1'b1;
		op <= o;
		source_contig <= s;
		dest_contig <= d;
		pair_increment <= pinc;
		distance <= dist_val;
		read_increment <= rinc;
		do @(posedge clk); while (busy);
		predict_links(o, s, d, pinc, dist_val, rinc);
	endtask

	task automatic add_link(logic [9:0] s, logic [9:0] d, logic [15:0] pinc,
			logic signed [20:0] dist_val, logic [15:0] rinc);
		send_item(OP_ADD, s, d, pinc, dist_val, rinc);
	endtask

	task automatic report_row(logic [9:0] s);
		send_item(OP_REPORT, s, 10'($urandom), 16'($urandom), 21'($urandom),
			16'($urandom));
	endtask

	// Wait out every expected result, then the tail of the last item.
	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Drains the pending results first, then writes both cutoffs back to back.
	task automatic set_cutoffs(logic [31:0] pairs_min, logic [31:0] reads_min);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= REG_PAIR_CUTOFF;
		cfg_data <= pairs_min;
		do @(posedge clk); while (!cfg_ready);
		pair_cutoff = pairs_min;
		cfg_index <= REG_READ_CUTOFF;
		cfg_data <= reads_min;
		do @(posedge clk); while (!cfg_ready);
		read_cutoff = reads_min;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Field extremes, new versus merged, report of an empty row, zero pair count.
	task automatic test_directed_adds();
		add_link(10'd0, 10'd0, 16'd0, 21'sd0, 16'd0);
		add_link(10'd0, 10'd1023, 16'hFFFF, 21'sd1048575, 16'hFFFF);
		add_link(10'd0, 10'd1023, 16'hFFFF, -21'sd1048576, 16'hFFFF);
		add_link(10'd1023, 10'd1023, 16'd1, -21'sd1048576, 16'd1);
		add_link(10'd1023, 10'd0, 16'd3, -21'sd7, 16'd0);
		add_link(10'd1023, 10'd0, 16'd4, 21'sd2, 16'd5);
		add_link(10'd682, 10'd341, 16'hAAAA, 21'sh0AAAAA, 16'h5555);
		add_link(10'd341, 10'd682, 16'h5555, 21'sh155555, 16'hAAAA);
		report_row(10'd0);
		report_row(10'd1023);
		report_row(10'd700);
		set_cutoffs(32'd0, 32'd0);
		report_row(10'd0);
		report_row(10'd1023);
		report_row(10'd682);
		report_row(10'd341);
	endtask

	// Fill one row, overflow it, then merge into the full row.
	task automatic test_full_row();
		for (int i = 0; i < ROW_SLOTS; i++)
			add_link(10'd5, 10'(i * 61), 16'(i + 1), 21'(i * 1000 - 7000), 16'(i));
		add_link(10'd5, 10'd999, 16'd9, 21'sd9, 16'd9);
		add_link(10'd5, 10'(3 * 61), 16'd2, -21'sd5, 16'd2);
		report_row(10'd5);
	endtask

	// Merge runs of extreme products both ways, then reports at the count extremes.
	task automatic test_large_merges();
		add_link(10'd900, 10'd1, 16'hFFFF, 21'sd1048575, 16'hFFFF);
		for (int i = 0; i < 5; i++)
			add_link(10'd900, 10'd1, 16'hFFFF, 21'sd1048575, 16'hFFFF);
		add_link(10'd900, 10'd2, 16'hFFFF, -21'sd1048576, 16'd0);
		for (int i = 0; i < 5; i++)
			add_link(10'd900, 10'd2, 16'hFFFF, -21'sd1048576, 16'd0);
		set_cutoffs(CNT_SAT, CNT_SAT);
		report_row(10'd900);
		report_row(10'd5);
		set_cutoffs(32'd0, 32'd0);
		report_row(10'd900);
	endtask

	// Mostly adds on a few busy rows so merges and full rows recur; some noise.
	task automatic test_random_mix(int items);
		logic [9:0] s, d;
		for (int i = 0; i < items; i++) begin
			s = ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'(32 + $urandom_range(0, 5));
			d = ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(0, 22));
			if ($urandom_range(0, 4) == 0)
				report_row(s);
			else
				add_link(s, d, ($urandom_range(0, 3) == 0) ? 16'($urandom) :
					16'($urandom_range(0, 20)), 21'($urandom), 16'($urandom_range(0, 9)));
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_adds();
		test_full_row();
		set_cutoffs(32'd1, 32'd1);
		sender_gaps = 1'b1;
		test_random_mix(70);
		set_cutoffs(32'd20, 32'd3);
		test_random_mix(60);
		set_cutoffs($urandom_range(0, 40), $urandom_range(0, 4));
		test_large_merges();
		sender_gaps = 1'b0;
		test_random_mix(50);
		drain_results();
		repeat (100) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/plat_pkg.sv
rtl/plat_div.sv
rtl/pair_link_accumulate_table.sv
verif/tb_pair_link_accumulate_table.sv
